>>> hw/rtl/jvs_pkg.sv
// Shared types and constants for the JSON value skipper.
// Used by every module under hw/rtl; depends on nothing.
package jvs_pkg;

    // Deepest nesting of objects and arrays that the stack holds.
    localparam int NEST_DEPTH = 32;
    localparam int LVL_W      = $clog2(NEST_DEPTH + 1);
    localparam int STK_IW     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 24;
    localparam int STAT_W = 4;
    localparam int LIT_W  = 3;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Container kinds held in the stack.
    localparam logic KIND_OBJ = 1'b0;
    localparam logic KIND_ARR = 1'b1;

    // Characters the parser looks for.
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LO_E   = 8'h65;
    localparam logic [BYTE_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LO_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LO_N   = 8'h6E;

    typedef enum logic [3:0] {
        MODE_VALUE,
        MODE_NUMBER,
        MODE_STRING,
        MODE_LIT_T,
        MODE_LIT_F,
        MODE_LIT_N,
        MODE_OBJ_OPEN,
        MODE_KEY,
        MODE_COLON,
        MODE_AFTER,
        MODE_OBJ_COMMA,
        MODE_OBJ_KEYWAIT,
        MODE_ARR_OPEN,
        MODE_ARR_COMMA
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK               = 4'd0,
        ST_NO_VALUE         = 4'd1,
        ST_OPEN_STRING      = 4'd2,
        ST_OBJ_END_EARLY    = 4'd3,
        ST_KEY_EXPECTED     = 4'd4,
        ST_KEY_OPEN         = 4'd5,
        ST_COLON_EXPECTED   = 4'd6,
        ST_BRACE_EXPECTED   = 4'd7,
        ST_ARR_END_EARLY    = 4'd8,
        ST_BRACKET_EXPECTED = 4'd9,
        ST_UNKNOWN_VALUE    = 4'd10,
        ST_TOO_DEEP         = 4'd11
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [LIT_W-1:0]   lit;
        logic               esc;
        logic [LVL_W-1:0]   level;
        logic [POS_W-1:0]   pos;
        logic               reported;
    } t_parse_state;

    typedef struct packed {
        logic              en;
        logic [STK_IW-1:0] idx;
        logic              kind;
    } t_stack_wr;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [POS_W-1:0] offset;
    } t_report;

    localparam t_parse_state STATE_RESET = '{
        mode:     MODE_VALUE,
        lit:      '0,
        esc:      1'b0,
        level:    '0,
        pos:      '0,
        reported: 1'b0
    };

    // Expected byte of a keyword literal at a given progress.
    function automatic logic [BYTE_W-1:0] lit_char(t_mode mode, logic [LIT_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        ch = 8'h00;
        case (mode)
            MODE_LIT_T: begin
                case (idx)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            MODE_LIT_F: begin
                case (idx)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            MODE_LIT_N: begin
                case (idx)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [LIT_W-1:0] lit_len(t_mode mode);
        logic [LIT_W-1:0] len;
        case (mode)
            MODE_LIT_F: len = 3'd5;
            default:    len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/jvs_in_stage.sv
// Input register of the JSON value skipper: holds one request until the parser takes it.
// Depends on jvs_pkg.
module jvs_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [jvs_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eot,
    input  logic                       i_take,
    output logic                       o_valid,
    output logic [jvs_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_eot
);
    import jvs_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eot;

    // The register refills in the same cycle that the parser drains it.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eot  <= i_eot;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eot   = r_eot;

endmodule

>>> hw/rtl/jvs_nest_stack.sv
// Container kind stack of the JSON value skipper, one bit per open object or array.
// Depends on jvs_pkg.
module jvs_nest_stack (
    input  logic                       i_clk,
    input  jvs_pkg::t_stack_wr         i_wr,
    input  logic [jvs_pkg::STK_IW-1:0] i_rd_idx,
    output logic                       o_rd_kind
);
    import jvs_pkg::*;

    // Entries above the nesting level are never read, so none are cleared.
    logic r_entry [NEST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_entry[i_wr.idx] <= i_wr.kind;
        end
    end

    assign o_rd_kind = r_entry[i_rd_idx];

endmodule

>>> hw/rtl/jvs_step.sv
// Next-state logic of the JSON value skipper: one text byte against the parse state.
// Depends on jvs_pkg; the top kind comes from jvs_nest_stack.
module jvs_step (
    input  jvs_pkg::t_parse_state      i_state,
    input  logic [jvs_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eot,
    input  logic                       i_top_kind,
    output jvs_pkg::t_parse_state      o_state,
    output jvs_pkg::t_stack_wr         o_stack_wr,
    output jvs_pkg::t_report           o_report
);
    import jvs_pkg::*;

    function automatic logic is_ws(logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_num_body(logic [BYTE_W-1:0] c);
        return is_digit(c) || (c == CH_DOT) || (c == CH_MINUS) ||
               (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

    function automatic t_status end_status(t_mode mode);
        t_status s;
        case (mode)
            MODE_VALUE:       s = ST_NO_VALUE;
            MODE_NUMBER:      s = ST_OK;
            MODE_STRING:      s = ST_OPEN_STRING;
            MODE_OBJ_OPEN:    s = ST_OBJ_END_EARLY;
            MODE_OBJ_KEYWAIT: s = ST_KEY_EXPECTED;
            MODE_KEY:         s = ST_KEY_OPEN;
            MODE_COLON:       s = ST_COLON_EXPECTED;
            MODE_OBJ_COMMA:   s = ST_BRACE_EXPECTED;
            MODE_ARR_OPEN:    s = ST_ARR_END_EARLY;
            MODE_ARR_COMMA:   s = ST_BRACKET_EXPECTED;
            MODE_AFTER:       s = ST_OK;
            default:          s = ST_UNKNOWN_VALUE;
        endcase
        return s;
    endfunction

    t_parse_state     n_state;
    t_stack_wr        n_wr;
    t_report          n_rep;
    logic [POS_W-1:0] next_pos;
    logic             kind;
    logic             do_start;
    logic             do_after;
    logic             do_close;
    logic             do_vdone;
    logic             do_open;
    logic             open_kind;
    t_mode            open_mode;
    logic [LVL_W-1:0] lvl_closed;
    logic [LIT_W-1:0] lit_next;

    assign next_pos = (i_state.pos == POS_MAX) ? POS_MAX : i_state.pos + 1'b1;
    assign kind     = (i_state.level == '0) ? KIND_OBJ : i_top_kind;
    assign lit_next = i_state.lit + 1'b1;

    always_comb begin
        n_state    = i_state;
        n_state.pos = next_pos;
        n_wr       = '0;
        n_rep      = '{valid: 1'b0, status: ST_OK, offset: next_pos};
        do_start   = 1'b0;
        do_after   = 1'b0;
        do_close   = 1'b0;
        do_vdone   = 1'b0;
        do_open    = 1'b0;
        open_kind  = KIND_OBJ;
        open_mode  = MODE_OBJ_OPEN;
        lvl_closed = i_state.level;

        if (!i_state.reported) begin
            case (i_state.mode)
                MODE_VALUE: begin
                    do_start = !is_ws(i_byte);
                end
                MODE_NUMBER: begin
                    // A number ends before the byte that terminates it.
                    if (!is_num_body(i_byte)) begin
                        if (i_state.level == '0) begin
                            n_rep = '{valid: 1'b1, status: ST_OK, offset: i_state.pos};
                        end else begin
                            do_after = 1'b1;
                        end
                    end
                end
                MODE_STRING, MODE_KEY: begin
                    if (i_state.esc) begin
                        n_state.esc = 1'b0;
                    end else if (i_byte == CH_BSLASH) begin
                        n_state.esc = 1'b1;
                    end else if (i_byte == CH_QUOTE) begin
                        if (i_state.mode == MODE_KEY) begin
                            n_state.mode = MODE_COLON;
                        end else begin
                            do_vdone = 1'b1;
                        end
                    end
                end
                MODE_LIT_T, MODE_LIT_F, MODE_LIT_N: begin
                    if (i_state.lit < lit_len(i_state.mode) &&
                        i_byte == lit_char(i_state.mode, i_state.lit)) begin
                        n_state.lit = lit_next;
                        do_vdone    = (lit_next == lit_len(i_state.mode));
                    end else begin
                        n_rep.valid  = 1'b1;
                        n_rep.status = ST_UNKNOWN_VALUE;
                    end
                end
                MODE_OBJ_OPEN: begin
                    if (is_ws(i_byte)) begin
                        n_state.mode = MODE_OBJ_OPEN;
                    end else if (i_byte == CH_RBRACE) begin
                        do_close = 1'b1;
                    end else if (i_byte == CH_QUOTE) begin
                        n_state.mode = MODE_KEY;
                        n_state.esc  = 1'b0;
                    end else begin
                        n_rep.valid  = 1'b1;
                        n_rep.status = ST_KEY_EXPECTED;
                    end
                end
                MODE_OBJ_COMMA, MODE_OBJ_KEYWAIT: begin
                    if (is_ws(i_byte)) begin
                        n_state.mode = MODE_OBJ_KEYWAIT;
                    end else if (i_byte == CH_QUOTE) begin
                        n_state.mode = MODE_KEY;
                        n_state.esc  = 1'b0;
                    end else begin
                        n_rep.valid  = 1'b1;
                        n_rep.status = ST_KEY_EXPECTED;
                    end
                end
                MODE_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_state.mode = MODE_VALUE;
                    end else if (!is_ws(i_byte)) begin
                        n_rep.valid  = 1'b1;
                        n_rep.status = ST_COLON_EXPECTED;
                    end
                end
                MODE_AFTER: begin
                    do_after = 1'b1;
                end
                MODE_ARR_OPEN: begin
                    if (i_byte == CH_RBRACK) begin
                        do_close = 1'b1;
                    end else begin
                        do_start = !is_ws(i_byte);
                    end
                end
                MODE_ARR_COMMA: begin
                    if (is_ws(i_byte)) begin
                        n_state.mode = MODE_VALUE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                default: begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = ST_UNKNOWN_VALUE;
                end
            endcase

            // Separator or closer after a finished member.
            if (do_after) begin
                n_state.mode = MODE_AFTER;
                if (is_ws(i_byte)) begin
                    n_state.mode = MODE_AFTER;
                end else if (i_byte == CH_COMMA) begin
                    n_state.mode = (kind == KIND_ARR) ? MODE_ARR_COMMA : MODE_OBJ_COMMA;
                end else if ((i_byte == CH_RBRACE && kind == KIND_OBJ) ||
                             (i_byte == CH_RBRACK && kind == KIND_ARR)) begin
                    do_close = 1'b1;
                end else begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = (kind == KIND_ARR) ? ST_BRACKET_EXPECTED
                                                      : ST_BRACE_EXPECTED;
                end
            end

            // First byte of a value.
            if (do_start) begin
                if (is_digit(i_byte) || i_byte == CH_MINUS) begin
                    n_state.mode = MODE_NUMBER;
                end else if (i_byte == CH_QUOTE) begin
                    n_state.mode = MODE_STRING;
                    n_state.esc  = 1'b0;
                end else if (i_byte == CH_LBRACE) begin
                    do_open   = 1'b1;
                    open_kind = KIND_OBJ;
                    open_mode = MODE_OBJ_OPEN;
                end else if (i_byte == CH_LBRACK) begin
                    do_open   = 1'b1;
                    open_kind = KIND_ARR;
                    open_mode = MODE_ARR_OPEN;
                end else if (i_byte == CH_LO_T) begin
                    n_state.mode = MODE_LIT_T;
                    n_state.lit  = 3'd1;
                end else if (i_byte == CH_LO_F) begin
                    n_state.mode = MODE_LIT_F;
                    n_state.lit  = 3'd1;
                end else if (i_byte == CH_LO_N) begin
                    n_state.mode = MODE_LIT_N;
                    n_state.lit  = 3'd1;
                end else begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = ST_UNKNOWN_VALUE;
                end
            end

            if (do_open) begin
                if (i_state.level >= LVL_W'(NEST_DEPTH)) begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = ST_TOO_DEEP;
                end else begin
                    n_wr.en       = 1'b1;
                    n_wr.idx      = i_state.level[STK_IW-1:0];
                    n_wr.kind     = open_kind;
                    n_state.level = i_state.level + 1'b1;
                    n_state.mode  = open_mode;
                end
            end

            // Closing a container finishes a value one level further out.
            if (do_close) begin
                if (i_state.level != '0) begin
                    lvl_closed = i_state.level - 1'b1;
                end
                n_state.level = lvl_closed;
                if (lvl_closed == '0) begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = ST_OK;
                end else begin
                    n_state.mode = MODE_AFTER;
                end
            end

            if (do_vdone) begin
                if (i_state.level == '0) begin
                    n_rep.valid  = 1'b1;
                    n_rep.status = ST_OK;
                end else begin
                    n_state.mode = MODE_AFTER;
                end
            end

            if (n_rep.valid) begin
                n_state.reported = 1'b1;
            end
        end

        if (i_eot && !n_state.reported) begin
            n_rep = '{valid: 1'b1, status: end_status(n_state.mode), offset: next_pos};
        end

        // The last byte of a document readies the parser for the next one.
        if (i_eot) begin
            n_state = STATE_RESET;
        end
    end

    assign o_state    = n_state;
    assign o_stack_wr = n_wr;
    assign o_report   = n_rep;

endmodule

>>> hw/rtl/json_value_skipper_core.sv
// Top level of the JSON value skipper: input register, parser step, nesting stack, result register.
// Depends on jvs_pkg, jvs_in_stage, jvs_nest_stack and jvs_step.
//
// Usage: the text of a JSON document enters one byte per request on the input
// channel (i_text_byte, with i_end_of_text set on the final byte). The block
// skips leading whitespace, scans exactly one value and sends one request on
// the output channel per document: o_status (zero for ok, else a syntax error
// code) and o_end_offset, the byte count just past the value. Bytes after the
// report are consumed silently until the end-of-text byte, which readies the
// parser for the next document.
// Throughput is one byte per cycle unless a result waits on a stalled receiver.
// Each byte is registered at the input and then handled by a single pass of the
// next-state logic, which also reads and writes the nesting stack; a result it
// yields is then registered in the output register.
// When the receiver stalls, the result waits in the output register while the
// input register still takes one more byte; further bytes wait only if that
// byte would produce a second result. Bytes that produce no result keep
// flowing even while a result waits.
// Synchronous reset returns the parser to expecting a value at offset zero and
// empties both registers; the stack contents are left as they are, since only
// entries below the nesting level are ever read.
module json_value_skipper_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [jvs_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                       i_end_of_text,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [jvs_pkg::STAT_W-1:0] o_status,
    output logic [jvs_pkg::POS_W-1:0]  o_end_offset
);
    import jvs_pkg::*;

    logic              stg_valid;
    logic [BYTE_W-1:0] stg_byte;
    logic              stg_eot;
    logic              take;
    logic              out_free;
    logic              top_kind;
    logic [STK_IW-1:0] top_idx;
    logic [LVL_W-1:0]  top_lvl;

    t_parse_state     r_state;
    t_parse_state     n_state;
    t_stack_wr        stack_wr;
    t_report          step_rep;

    logic             r_out_valid;
    t_status          r_status;
    logic [POS_W-1:0] r_offset;

    jvs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_text_byte),
        .i_eot   (i_end_of_text),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_byte  (stg_byte),
        .o_eot   (stg_eot)
    );

    // The top of stack sits one below the level; at level zero the value is unused.
    assign top_lvl = r_state.level - 1'b1;
    assign top_idx = top_lvl[STK_IW-1:0];

    jvs_nest_stack u_stack (
        .i_clk     (i_clk),
        .i_wr      (take ? stack_wr : t_stack_wr'('0)),
        .i_rd_idx  (top_idx),
        .o_rd_kind (top_kind)
    );

    jvs_step u_step (
        .i_state    (r_state),
        .i_byte     (stg_byte),
        .i_eot      (stg_eot),
        .i_top_kind (top_kind),
        .o_state    (n_state),
        .o_stack_wr (stack_wr),
        .o_report   (step_rep)
    );

    // A byte that yields no result never waits on the output side.
    assign out_free = !r_out_valid || i_out_ready;
    assign take     = stg_valid && (!step_rep.valid || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && step_rep.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && step_rep.valid) begin
            r_status <= step_rep.status;
            r_offset <= step_rep.offset;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_end_offset = r_offset;

endmodule

>>> hw/rtl/jvs_checker.sv
// Port-level checks for the JSON value skipper, bound to json_value_skipper_core.
// Depends on jvs_pkg for port widths.
module jvs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [jvs_pkg::BYTE_W-1:0] i_text_byte,
    input logic                       i_end_of_text,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [jvs_pkg::STAT_W-1:0] o_status,
    input logic [jvs_pkg::POS_W-1:0]  o_end_offset
);
    import jvs_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_end_offset))
        else $error("result changed while stalled");

    // Input backpressure only arises from a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // Every result covers at least one byte.
    a_offset_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_end_offset != '0)
        else $error("result with zero end offset");

    // Reset empties the output side.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Status codes stop at the too-deep error.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= STAT_W'(ST_TOO_DEEP))
        else $error("status code out of range");

endmodule

bind json_value_skipper_core jvs_checker u_jvs_checker (.*);

>>> tb/json_value_skipper_core_tb.sv
// Testbench for json_value_skipper_core: streams JSON documents in and checks the reports.
// Depends on jvs_pkg and the RTL of json_value_skipper_core; needs no other file.
`timescale 1ns / 100ps

module json_value_skipper_core_tb;
    import jvs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 165;

    // One report of the block: status code and offset just past the value.
    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] offset;
    } t_skip_result;

    // Scoreboard with its own copy of the parser state. Every accepted byte before
    // a document's report is stepped through the parser, and each report it predicts
    // is queued until the block sends the matching result request.
    class skipper_scoreboard;
        t_mode            mode;
        logic [LIT_W-1:0] lit_seen;
        bit               escaped;
        logic             kinds[NEST_DEPTH];
        int               level;
        logic [POS_W-1:0] position;
        bit               reported;
        t_skip_result     due[$];
        int               errors;
        int               parsed_bytes;
        int               docs;
        int               ok_docs;
        int               deepest;
        logic [11:0]      status_seen;

        function new();
            errors       = 0;
            parsed_bytes = 0;
            docs         = 0;
            ok_docs      = 0;
            deepest      = 0;
            status_seen  = '0;
            clear_parse();
        endfunction

        function void clear_parse();
            mode     = MODE_VALUE;
            lit_seen = '0;
            escaped  = 1'b0;
            level    = 0;
            position = '0;
            reported = 1'b0;
        endfunction

        function bit is_space(logic [BYTE_W-1:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
        endfunction

        function bit is_digit(logic [BYTE_W-1:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit in_number(logic [BYTE_W-1:0] c);
            return is_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_LO_E || c == CH_UP_E;
        endfunction

        function void post(t_status s, logic [POS_W-1:0] off);
            t_skip_result r;
            r.status = s;
            r.offset = off;
            due.insert(due.size(), r);
            reported = 1'b1;
        endfunction

        function logic top_kind();
            if (level == 0)
                return KIND_OBJ;
            return kinds[level-1];
        endfunction

        function void value_finished(logic [POS_W-1:0] off);
            if (level == 0)
                post(ST_OK, off);
            else
                mode = MODE_AFTER;
        endfunction

        function void close_level(logic [POS_W-1:0] off);
            if (level > 0)
                level--;
            value_finished(off);
        endfunction

        function void open_level(logic kind, t_mode m, logic [POS_W-1:0] off);
            if (level >= NEST_DEPTH) begin
                post(ST_TOO_DEEP, off);
                return;
            end
            kinds[level] = kind;
            level++;
            if (level > deepest)
                deepest = level;
            mode = m;
        endfunction

        function void start_value(logic [BYTE_W-1:0] c, logic [POS_W-1:0] off);
            if (is_digit(c) || c == CH_MINUS) begin
                mode = MODE_NUMBER;
            end else if (c == CH_QUOTE) begin
                mode    = MODE_STRING;
                escaped = 1'b0;
            end else if (c == CH_LBRACE) begin
                open_level(KIND_OBJ, MODE_OBJ_OPEN, off);
            end else if (c == CH_LBRACK) begin
                open_level(KIND_ARR, MODE_ARR_OPEN, off);
            end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
                mode = (c == CH_LO_T) ? MODE_LIT_T : (c == CH_LO_F) ? MODE_LIT_F : MODE_LIT_N;
                lit_seen = 3'd1;
            end else begin
                post(ST_UNKNOWN_VALUE, off);
            end
        endfunction

        function void literal_step(logic [BYTE_W-1:0] c, logic [POS_W-1:0] off, string word);
            if (lit_seen < word.len() && c == word[lit_seen]) begin
                lit_seen++;
                if (lit_seen == word.len())
                    value_finished(off);
            end else begin
                post(ST_UNKNOWN_VALUE, off);
            end
        endfunction

        function void string_step(logic [BYTE_W-1:0] c, logic [POS_W-1:0] off, bit is_key);
            if (escaped)
                escaped = 1'b0;
            else if (c == CH_BSLASH)
                escaped = 1'b1;
            else if (c == CH_QUOTE) begin
                if (is_key)
                    mode = MODE_COLON;
                else
                    value_finished(off);
            end
        endfunction

        function void after_step(logic [BYTE_W-1:0] c, logic [POS_W-1:0] off);
            logic kind;
            kind = top_kind();
            if (is_space(c))
                return;
            if (c == CH_COMMA)
                mode = (kind == KIND_ARR) ? MODE_ARR_COMMA : MODE_OBJ_COMMA;
            else if ((c == CH_RBRACE && kind == KIND_OBJ) || (c == CH_RBRACK && kind == KIND_ARR))
                close_level(off);
            else
                post((kind == KIND_ARR) ? ST_BRACKET_EXPECTED : ST_BRACE_EXPECTED, off);
        endfunction

        function void byte_step(logic [BYTE_W-1:0] c, logic [POS_W-1:0] here,
                                logic [POS_W-1:0] off);
            case (mode)
                MODE_VALUE: begin
                    if (!is_space(c))
                        start_value(c, off);
                end
                MODE_NUMBER: begin
                    // The byte that ends a number is not part of it, but it
                    // still has to be parsed as what follows the value.
                    if (!in_number(c)) begin
                        value_finished(here);
                        if (!reported)
                            after_step(c, off);
                    end
                end
                MODE_STRING: string_step(c, off, 1'b0);
                MODE_KEY:    string_step(c, off, 1'b1);
                MODE_LIT_T:  literal_step(c, off, "true");
                MODE_LIT_F:  literal_step(c, off, "false");
                MODE_LIT_N:  literal_step(c, off, "null");
                MODE_OBJ_OPEN: begin
                    if (!is_space(c)) begin
                        if (c == CH_RBRACE)
                            close_level(off);
                        else if (c == CH_QUOTE) begin
                            mode    = MODE_KEY;
                            escaped = 1'b0;
                        end else
                            post(ST_KEY_EXPECTED, off);
                    end
                end
                MODE_OBJ_COMMA, MODE_OBJ_KEYWAIT: begin
                    if (is_space(c))
                        mode = MODE_OBJ_KEYWAIT;
                    else if (c == CH_QUOTE) begin
                        mode    = MODE_KEY;
                        escaped = 1'b0;
                    end else
                        post(ST_KEY_EXPECTED, off);
                end
                MODE_COLON: begin
                    if (!is_space(c)) begin
                        if (c == CH_COLON)
                            mode = MODE_VALUE;
                        else
                            post(ST_COLON_EXPECTED, off);
                    end
                end
                MODE_AFTER: after_step(c, off);
                MODE_ARR_OPEN: begin
                    if (!is_space(c)) begin
                        if (c == CH_RBRACK)
                            close_level(off);
                        else
                            start_value(c, off);
                    end
                end
                MODE_ARR_COMMA: begin
                    if (is_space(c))
                        mode = MODE_VALUE;
                    else
                        start_value(c, off);
                end
                default: post(ST_UNKNOWN_VALUE, off);
            endcase
        endfunction

        // Status when the text ends before the value is complete.
        function t_status status_at_end();
            case (mode)
                MODE_VALUE:       return ST_NO_VALUE;
                MODE_NUMBER:      return ST_OK;
                MODE_STRING:      return ST_OPEN_STRING;
                MODE_OBJ_OPEN:    return ST_OBJ_END_EARLY;
                MODE_OBJ_KEYWAIT: return ST_KEY_EXPECTED;
                MODE_KEY:         return ST_KEY_OPEN;
                MODE_COLON:       return ST_COLON_EXPECTED;
                MODE_OBJ_COMMA:   return ST_BRACE_EXPECTED;
                MODE_ARR_OPEN:    return ST_ARR_END_EARLY;
                MODE_ARR_COMMA:   return ST_BRACKET_EXPECTED;
                MODE_AFTER:       return ST_OK;
                default:          return ST_UNKNOWN_VALUE;
            endcase
        endfunction

        function void note_request(logic [BYTE_W-1:0] c, logic last);
            logic [POS_W-1:0] here;
            logic [POS_W-1:0] nxt;
            here     = position;
            nxt      = (here == POS_MAX) ? POS_MAX : here + 1'b1;
            position = nxt;
            if (!reported) begin
                parsed_bytes++;
                byte_step(c, here, nxt);
            end
            if (last && !reported)
                post(status_at_end(), nxt);
            if (last) begin
                docs++;
                clear_parse();
            end
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [POS_W-1:0] off);
            t_skip_result r;
            if (due.size() == 0) begin
                $display("%0t: unexpected result, status %0d offset %0d", $time, st, off);
                errors++;
                return;
            end
            r = due.pop_front();
            status_seen[r.status] = 1'b1;
            if (r.status == ST_OK)
                ok_docs++;
            if (st !== r.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, st);
                errors++;
            end
            if (off !== r.offset) begin
                $display("%0t: end offset mismatch, expected %0d, actual %0d",
                         $time, r.offset, off);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_text_byte   = '0;
    logic                 i_end_of_text = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [POS_W-1:0]     o_end_offset;

    skipper_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit hold_active   = 1'b0;

    logic [BYTE_W-1:0] doc_bytes[$];

    // Adds one byte to the end of the document being built.
    function automatic void append_byte(input logic [BYTE_W-1:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endfunction

    json_value_skipper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_end_offset  (o_end_offset)
    );

    always #4 i_clk = ~i_clk;

    // Both channels are observed at the rising edge; the testbench only
    // changes inputs at the falling edge, so these values are settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_status, o_end_offset);
            if (i_in_valid && o_in_ready)
                sb.note_request(i_text_byte, i_end_of_text);
        end
    end

    // Receiver: random stalls, or a long hold-off while a hold is running.
    always @(negedge i_clk) begin
        i_out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end

    // Long hold-off on the result side, counted here in clock cycles.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one byte, after a random gap, and waits until it is taken.
    // Valid stays high from one byte to the next when there is no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_doc();
        int i;
        if (doc_bytes.size() == 0)
            append_byte(CH_SPACE);
        for (i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        doc_bytes.delete();
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_doc();
    endtask

    // Sender pause: valid drops and nothing is offered until every
    // predicted report has come back.
    task automatic wait_for_reports();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic emit_blank();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            case ($urandom_range(3))
                0:       append_byte(CH_SPACE);
                1:       append_byte(CH_TAB);
                2:       append_byte(CH_LF);
                default: append_byte(CH_CR);
            endcase
        end
    endtask

    task automatic emit_number();
        string lead;
        string body;
        lead = "0123456789-";
        body = "0123456789.-eE";
        append_byte(lead[$urandom_range(lead.len() - 1)]);
        repeat ($urandom_range(0, 5))
            append_byte(body[$urandom_range(body.len() - 1)]);
    endtask

    task automatic emit_string();
        int ch;
        append_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(3) == 0) begin
                // An escape makes any following byte ordinary, a quote too.
                append_byte(CH_BSLASH);
                append_byte(8'($urandom_range(255)));
            end else begin
                do ch = $urandom_range(32, 126);
                while (ch == CH_QUOTE || ch == CH_BSLASH);
                append_byte(8'(ch));
            end
        end
        append_byte(CH_QUOTE);
    endtask

    task automatic emit_value(input int depth);
        int pick;
        int n;
        int i;
        pick = $urandom_range(9);
        if (depth >= 3 && pick >= 6)
            pick = $urandom_range(5);
        case (pick)
            0, 1, 2: emit_number();
            3, 4:    emit_string();
            5: begin
                case ($urandom_range(2))
                    0:       push_text("true");
                    1:       push_text("false");
                    default: push_text("null");
                endcase
            end
            6, 7: begin
                append_byte(CH_LBRACE);
                emit_blank();
                n = $urandom_range(3);
                for (i = 0; i < n; i++) begin
                    if (i > 0) begin
                        append_byte(CH_COMMA);
                        emit_blank();
                    end
                    emit_string();
                    emit_blank();
                    append_byte(CH_COLON);
                    emit_blank();
                    emit_value(depth + 1);
                    emit_blank();
                end
                append_byte(CH_RBRACE);
            end
            default: begin
                append_byte(CH_LBRACK);
                emit_blank();
                n = $urandom_range(3);
                for (i = 0; i < n; i++) begin
                    if (i > 0) begin
                        append_byte(CH_COMMA);
                        emit_blank();
                    end
                    emit_value(depth + 1);
                    emit_blank();
                end
                append_byte(CH_RBRACK);
            end
        endcase
    endtask

    // Nesting around the stack limit, mixing objects and arrays.
    task automatic emit_deep();
        bit is_arr[40];
        int n;
        int i;
        n = $urandom_range(28, 34);
        for (i = 0; i < n; i++) begin
            is_arr[i] = 1'($urandom_range(1));
            if (is_arr[i])
                append_byte(CH_LBRACK);
            else
                push_text("{\"k\":");
        end
        emit_value(3);
        for (i = n - 1; i >= 0; i--)
            append_byte(is_arr[i] ? CH_RBRACK : CH_RBRACE);
    endtask

    // Breaks a well-formed document: cut short, one byte replaced, or one
    // byte added.
    task automatic mutate_doc();
        int idx;
        idx = $urandom_range(doc_bytes.size() - 1);
        case ($urandom_range(2))
            0: begin
                while (doc_bytes.size() > idx + 1)
                    void'(doc_bytes.pop_back());
            end
            1:       doc_bytes[idx] = 8'($urandom_range(255));
            default: doc_bytes.insert(idx, 8'($urandom_range(255)));
        endcase
    endtask

    task automatic make_random_doc();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 6))
                append_byte(8'($urandom_range(255)));
        end else begin
            if (r < 11) begin
                emit_deep();
            end else begin
                emit_blank();
                emit_value(0);
            end
            if ($urandom_range(3) == 0) begin
                emit_blank();
                append_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(99) < 30)
                mutate_doc();
        end
    endtask

    task automatic run_phase(input int sp, input int rp, input int budget);
        int goal;
        send_idle_pct = sp;
        stall_pct     = rp;
        goal          = sb.parsed_bytes + budget;
        while (sb.parsed_bytes < goal) begin
            make_random_doc();
            send_doc();
        end
        wait_for_reports();
    endtask

    // Short documents that each report at once, sent while the receiver is
    // held off, so results pile up and the input side has to stall.
    task automatic fill_under_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        repeat (24) begin
            if ($urandom_range(1))
                send_text("9 ");
            else
                send_text("[]");
        end
        wait_for_reports();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed documents: each status code and the edge cases of the syntax.
        send_text(" \t\n\r-12.5e3 ");
        send_text("\"a\\\"b\\\\\"");
        send_text("true");
        send_text("fals");
        send_text("nulx");
        send_text("{\"k\":[1,false,{}],\"z\":null}");
        send_text("[1,");
        send_text("[1, ");
        send_text("{\"a\":1,");
        send_text("{\"a\":1,\t");
        send_text("{\"a\":1]");
        send_text("[1}");
        send_text("{");
        send_text("[ ");
        send_text("{\"a");
        send_text("{\"a\" x");
        send_text("{1");
        send_text("\"abc");
        send_text(" ");
        send_text("{\"a\":1");
        send_text("[[2");
        send_text("@");
        send_text("7 xyz");
        // One level past the stack, then exactly full.
        repeat (NEST_DEPTH + 1) append_byte(CH_LBRACK);
        append_byte(CH_RBRACK);
        send_doc();
        repeat (NEST_DEPTH) append_byte(CH_LBRACK);
        append_byte(CH_ZERO);
        repeat (NEST_DEPTH) append_byte(CH_RBRACK);
        send_doc();
        wait_for_reports();

        run_phase(0, 0, PHASE_BYTES);
        fill_under_hold();
        run_phase(83, 0, PHASE_BYTES);
        run_phase(0, 83, PHASE_BYTES);
        run_phase(28, 28, PHASE_BYTES);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d documents, %0d parsed bytes, %0d reported ok.",
                 sb.docs, sb.parsed_bytes, sb.ok_docs);
        $display("Deepest nesting %0d; status codes seen (bit per code) %b.",
                 sb.deepest, sb.status_seen);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
